FILE: rtl/sip_pkg.sv
`default_nettype none

package sip_pkg;

    // coordinate format: signed fixed point, binary point at FRAC_BITS
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;

    // derived widths of the exact intermediate values
    localparam int DIFF_BITS = COORD_BITS + 1;      // p_a - p_b
    localparam int PROD_BITS = 2 * DIFF_BITS;       // diff * diff
    localparam int DET_BITS  = PROD_BITS + 1;       // difference of two products
    localparam int NUM_BITS  = DET_BITS + DIFF_BITS; // tn * (p1_c - p2_c)

    // clock edges from the accepting edge to the edge that takes the result
    localparam int SIP_LATENCY = COORD_BITS + 14;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] p1_x;
        logic signed [COORD_BITS-1:0] p1_y;
        logic signed [COORD_BITS-1:0] p1_z;
        logic signed [COORD_BITS-1:0] p2_x;
        logic signed [COORD_BITS-1:0] p2_y;
        logic signed [COORD_BITS-1:0] p2_z;
        logic signed [COORD_BITS-1:0] p3_x;
        logic signed [COORD_BITS-1:0] p3_y;
        logic signed [COORD_BITS-1:0] p4_x;
        logic signed [COORD_BITS-1:0] p4_y;
    } sip_in_t;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
        logic signed [COORD_BITS-1:0] cross_z;
    } sip_out_t;

endpackage

`default_nettype wire

FILE: rtl/sip_mul.sv
`default_nettype none

// Signed multiplier, three stages: magnitudes, partial products of 16-bit slices, sum and sign.
module sip_mul #(
    parameter int WA = 33,
    parameter int WB = 33,
    parameter int TW = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic signed [WA-1:0]      a,
    input  logic signed [WB-1:0]      b,
    input  logic [TW-1:0]             tag,
    output logic                      out_valid,
    output logic signed [WA+WB-1:0]   p,
    output logic [TW-1:0]             out_tag
);

    localparam int CH = 16;
    localparam int NC = (WB + CH - 1) / CH;
    localparam int BP = NC * CH;
    localparam int PW = WA + CH;
    localparam int SW = WA + BP;

    logic [WA-1:0] ma_next, ma_reg;
    logic [WB-1:0] mb_mag;
    logic [BP-1:0] mb_reg;
    logic          neg_a_reg, neg_b_reg;
    logic [PW-1:0] pp_reg [NC];
    logic [TW-1:0] tag_a_reg, tag_b_reg, tag_c_reg;
    logic [2:0]    v_reg;
    logic [SW-1:0] sum;
    logic [WA+WB-1:0] p_next, p_reg;

    always_comb
    begin
        ma_next = a[WA-1] ? (~a + 1'b1) : a;
        mb_mag  = b[WB-1] ? (~b + 1'b1) : b;
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NC; i++)
        begin
            sum = sum + (SW'(pp_reg[i]) << (i * CH));
        end
        p_next = neg_b_reg ? (~sum[WA+WB-1:0] + 1'b1) : sum[WA+WB-1:0];
    end

    always_ff @(posedge clk)
    begin
        ma_reg    <= ma_next;
        mb_reg    <= BP'(mb_mag);
        neg_a_reg <= a[WA-1] ^ b[WB-1];
        tag_a_reg <= tag;
        for (int i = 0; i < NC; i++)
        begin
            pp_reg[i] <= PW'(ma_reg * mb_reg[i*CH +: CH]);
        end
        neg_b_reg <= neg_a_reg;
        tag_b_reg <= tag_a_reg;
        p_reg     <= p_next;
        tag_c_reg <= tag_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    assign out_valid = v_reg[2];
    assign p         = p_reg;
    assign out_tag   = tag_c_reg;

endmodule

`default_nettype wire

FILE: rtl/sip_div.sv
`default_nettype none

// Restoring divider of magnitudes, one quotient bit per stage.
// The quotient must fit QW bits (upper numerator part below the divisor).
module sip_div #(
    parameter int DW = 67,
    parameter int QW = 33,
    parameter int TW = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [DW+QW-1:0]  num,
    input  logic [DW-1:0]            den,
    input  logic [TW-1:0]            tag,
    output logic                     out_valid,
    output logic [QW-1:0]            q,
    output logic                     neg,
    output logic [TW-1:0]            out_tag
);

    localparam int NW = DW + QW;

    logic [NW-1:0] mag;
    logic [DW-1:0] rem_next [QW+1];
    logic [DW-1:0] rem_reg  [QW+1];
    logic [QW-1:0] low_next [QW+1];
    logic [QW-1:0] low_reg  [QW+1];
    logic [QW-1:0] q_next   [QW+1];
    logic [QW-1:0] q_reg    [QW+1];
    logic [DW-1:0] den_reg  [QW+1];
    logic          neg_reg  [QW+1];
    logic [TW-1:0] tag_reg  [QW+1];
    logic [QW:0]   v_reg;

    always_comb
    begin
        logic [DW:0] t;
        logic [DW:0] d;
        logic        ge;
        mag         = num[NW-1] ? (~num + 1'b1) : num;
        rem_next[0] = mag[NW-1:QW];
        low_next[0] = mag[QW-1:0];
        q_next[0]   = '0;
        for (int i = 0; i < QW; i++)
        begin
            t  = {rem_reg[i], low_reg[i][QW-1]};
            d  = t - {1'b0, den_reg[i]};
            ge = (t >= {1'b0, den_reg[i]});
            rem_next[i+1] = ge ? d[DW-1:0] : t[DW-1:0];
            low_next[i+1] = {low_reg[i][QW-2:0], 1'b0};
            q_next[i+1]   = {q_reg[i][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_next[0];
        low_reg[0] <= low_next[0];
        q_reg[0]   <= q_next[0];
        den_reg[0] <= den;
        neg_reg[0] <= num[NW-1];
        tag_reg[0] <= tag;
        for (int i = 1; i <= QW; i++)
        begin
            rem_reg[i] <= rem_next[i];
            low_reg[i] <= low_next[i];
            q_reg[i]   <= q_next[i];
            den_reg[i] <= den_reg[i-1];
            neg_reg[i] <= neg_reg[i-1];
            tag_reg[i] <= tag_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[QW-1:0], in_valid};
        end
    end

    // last remainder and last shifted low bits are dropped
    assign out_valid = v_reg[QW];
    assign q         = q_reg[QW];
    assign neg       = neg_reg[QW];
    assign out_tag   = tag_reg[QW];

endmodule

`default_nettype wire

FILE: rtl/segment_intersection_point.sv
`default_nettype none

// Segment intersection point, signed fixed point coordinates.
//
// Input item: segment p1-p2 (x, y, z) and segment p3-p4 (x, y) on item,
// taken at a rising edge with start high and busy low. busy is always low:
// the pipeline takes one item every clock cycle.
// Result item: hit and cross_x/y/z on result, marked by done for exactly one
// cycle; there is no back pressure, results come out in input order.
// On a miss (parallel segments, or t or s outside [0,1]) all coordinates are 0.
//
// Throughput is one item per cycle; the depth is set by the restoring divider,
// one quotient bit (COORD_BITS + 1 in all) per stage, behind two three-stage
// multiplier banks.
//
// Reset clears every valid bit in the pipeline; items in flight are dropped
// and done stays low until new items have passed through.
module segment_intersection_point (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sip_pkg::sip_in_t item,
    output logic             done,
    output sip_pkg::sip_out_t result
);

    import sip_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int D  = DIFF_BITS;
    localparam int PB = PROD_BITS;
    localparam int DB = DET_BITS;

    // ---------------- input register
    sip_in_t in_reg;
    logic    s0_v_reg;

    // ---------------- edge vectors
    logic signed [D-1:0] dx_next, dy_next, dz_next, ex_next, ey_next, fx_next, fy_next;
    logic signed [D-1:0] dx_reg, dy_reg, dz_reg, ex_reg, ey_reg, fx_reg, fy_reg;
    logic signed [W-1:0] p2x_reg, p2y_reg, p2z_reg;
    logic                s1_v_reg;

    // ---------------- first multiplier bank
    logic signed [PB-1:0] pr [6];
    logic [5:0]           pv;
    logic signed [D-1:0]  m_dx, m_dy, m_dz;
    logic signed [W-1:0]  m_p2x, m_p2y, m_p2z;

    // ---------------- det / numerators
    logic signed [DB-1:0] det_next, tn_next, sn_next;
    logic signed [DB-1:0] det_reg, tn_reg, sn_reg;
    logic signed [D-1:0]  c_dx_reg, c_dy_reg, c_dz_reg;
    logic signed [W-1:0]  c_p2x_reg, c_p2y_reg, c_p2z_reg;
    logic                 c_v_reg;

    // ---------------- magnitudes and signs
    logic [DB-1:0]        mdet_reg, mtn_reg, msn_reg;
    logic signed [DB-1:0] tadj_reg;
    logic                 det_zero_reg, tn_bad_reg, sn_bad_reg;
    logic signed [D-1:0]  a_dx_reg, a_dy_reg, a_dz_reg;
    logic signed [W-1:0]  a_p2x_reg, a_p2y_reg, a_p2z_reg;
    logic                 a_v_reg;

    // ---------------- range test
    logic                 hit_next;
    logic                 k_hit_reg;
    logic [DB-1:0]        k_mdet_reg;
    logic signed [DB-1:0] k_tadj_reg;
    logic signed [D-1:0]  k_dx_reg, k_dy_reg, k_dz_reg;
    logic signed [W-1:0]  k_p2x_reg, k_p2y_reg, k_p2z_reg;
    logic                 k_v_reg;

    // ---------------- second multiplier bank and dividers
    localparam int T2 = 1 + DB + W;
    localparam int T3 = 1 + W;
    logic signed [NUM_BITS-1:0] np [3];
    logic [T2-1:0]              nt [3];
    logic [2:0]                 nv;
    logic [D-1:0]               qq [3];
    logic [2:0]                 qn;
    logic [T3-1:0]              qt [3];
    logic [2:0]                 qv;

    // ---------------- output
    sip_out_t out_next, out_reg;
    logic     done_reg;

    assign busy = 1'b0;

    // stage: input capture
    always_ff @(posedge clk)
    begin
        in_reg <= item;
    end

    // stage: coordinate differences, exact at W+1 bits
    always_comb
    begin
        dx_next = {in_reg.p1_x[W-1], in_reg.p1_x} - {in_reg.p2_x[W-1], in_reg.p2_x};
        dy_next = {in_reg.p1_y[W-1], in_reg.p1_y} - {in_reg.p2_y[W-1], in_reg.p2_y};
        dz_next = {in_reg.p1_z[W-1], in_reg.p1_z} - {in_reg.p2_z[W-1], in_reg.p2_z};
        ex_next = {in_reg.p4_x[W-1], in_reg.p4_x} - {in_reg.p3_x[W-1], in_reg.p3_x};
        ey_next = {in_reg.p4_y[W-1], in_reg.p4_y} - {in_reg.p3_y[W-1], in_reg.p3_y};
        fx_next = {in_reg.p4_x[W-1], in_reg.p4_x} - {in_reg.p2_x[W-1], in_reg.p2_x};
        fy_next = {in_reg.p4_y[W-1], in_reg.p4_y} - {in_reg.p2_y[W-1], in_reg.p2_y};
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        dz_reg  <= dz_next;
        ex_reg  <= ex_next;
        ey_reg  <= ey_next;
        fx_reg  <= fx_next;
        fy_reg  <= fy_next;
        p2x_reg <= in_reg.p2_x;
        p2y_reg <= in_reg.p2_y;
        p2z_reg <= in_reg.p2_z;
    end

    // six cross products; the values needed later ride along as tags
    sip_mul #(.WA(D), .WB(D), .TW(D)) u_mul_0 (
        .clk(clk), .rst_n(rst_n), .in_valid(s1_v_reg), .a(dx_reg), .b(ey_reg),
        .tag(dx_reg), .out_valid(pv[0]), .p(pr[0]), .out_tag(m_dx));
    sip_mul #(.WA(D), .WB(D), .TW(D)) u_mul_1 (
        .clk(clk), .rst_n(rst_n), .in_valid(s1_v_reg), .a(ex_reg), .b(dy_reg),
        .tag(dy_reg), .out_valid(pv[1]), .p(pr[1]), .out_tag(m_dy));
    sip_mul #(.WA(D), .WB(D), .TW(D)) u_mul_2 (
        .clk(clk), .rst_n(rst_n), .in_valid(s1_v_reg), .a(ey_reg), .b(fx_reg),
        .tag(dz_reg), .out_valid(pv[2]), .p(pr[2]), .out_tag(m_dz));
    sip_mul #(.WA(D), .WB(D), .TW(W)) u_mul_3 (
        .clk(clk), .rst_n(rst_n), .in_valid(s1_v_reg), .a(ex_reg), .b(fy_reg),
        .tag(p2x_reg), .out_valid(pv[3]), .p(pr[3]), .out_tag(m_p2x));
    sip_mul #(.WA(D), .WB(D), .TW(W)) u_mul_4 (
        .clk(clk), .rst_n(rst_n), .in_valid(s1_v_reg), .a(dy_reg), .b(fx_reg),
        .tag(p2y_reg), .out_valid(pv[4]), .p(pr[4]), .out_tag(m_p2y));
    sip_mul #(.WA(D), .WB(D), .TW(W)) u_mul_5 (
        .clk(clk), .rst_n(rst_n), .in_valid(s1_v_reg), .a(dx_reg), .b(fy_reg),
        .tag(p2z_reg), .out_valid(pv[5]), .p(pr[5]), .out_tag(m_p2z));

    // det = dx*ey - ex*dy, tn = ey*fx - ex*fy, sn = dx*fy - dy*fx
    always_comb
    begin
        det_next = {pr[0][PB-1], pr[0]} - {pr[1][PB-1], pr[1]};
        tn_next  = {pr[2][PB-1], pr[2]} - {pr[3][PB-1], pr[3]};
        sn_next  = {pr[5][PB-1], pr[5]} - {pr[4][PB-1], pr[4]};
    end

    always_ff @(posedge clk)
    begin
        det_reg   <= det_next;
        tn_reg    <= tn_next;
        sn_reg    <= sn_next;
        c_dx_reg  <= m_dx;
        c_dy_reg  <= m_dy;
        c_dz_reg  <= m_dz;
        c_p2x_reg <= m_p2x;
        c_p2y_reg <= m_p2y;
        c_p2z_reg <= m_p2z;
    end

    // magnitudes; a numerator of opposite sign to det (and nonzero) misses.
    // tn is folded to det's sign so the divider sees a positive divisor.
    always_ff @(posedge clk)
    begin
        mdet_reg     <= det_reg[DB-1] ? (~det_reg + 1'b1) : det_reg;
        mtn_reg      <= tn_reg[DB-1]  ? (~tn_reg + 1'b1)  : tn_reg;
        msn_reg      <= sn_reg[DB-1]  ? (~sn_reg + 1'b1)  : sn_reg;
        tadj_reg     <= det_reg[DB-1] ? (~tn_reg + 1'b1)  : tn_reg;
        det_zero_reg <= (det_reg == '0);
        tn_bad_reg   <= (tn_reg[DB-1] != det_reg[DB-1]) && (tn_reg != '0);
        sn_bad_reg   <= (sn_reg[DB-1] != det_reg[DB-1]) && (sn_reg != '0);
        a_dx_reg     <= c_dx_reg;
        a_dy_reg     <= c_dy_reg;
        a_dz_reg     <= c_dz_reg;
        a_p2x_reg    <= c_p2x_reg;
        a_p2y_reg    <= c_p2y_reg;
        a_p2z_reg    <= c_p2z_reg;
    end

    // 0 <= t, s <= 1 by magnitude compare against |det|
    assign hit_next = !det_zero_reg && !tn_bad_reg && !sn_bad_reg &&
                      (mtn_reg <= mdet_reg) && (msn_reg <= mdet_reg);

    always_ff @(posedge clk)
    begin
        k_hit_reg  <= hit_next;
        k_mdet_reg <= mdet_reg;
        k_tadj_reg <= tadj_reg;
        k_dx_reg   <= a_dx_reg;
        k_dy_reg   <= a_dy_reg;
        k_dz_reg   <= a_dz_reg;
        k_p2x_reg  <= a_p2x_reg;
        k_p2y_reg  <= a_p2y_reg;
        k_p2z_reg  <= a_p2z_reg;
    end

    // tn * (p1_c - p2_c), then divided by |det|, per coordinate
    sip_mul #(.WA(DB), .WB(D), .TW(T2)) u_mul_x (
        .clk(clk), .rst_n(rst_n), .in_valid(k_v_reg), .a(k_tadj_reg), .b(k_dx_reg),
        .tag({k_hit_reg, k_mdet_reg, k_p2x_reg}),
        .out_valid(nv[0]), .p(np[0]), .out_tag(nt[0]));
    sip_mul #(.WA(DB), .WB(D), .TW(T2)) u_mul_y (
        .clk(clk), .rst_n(rst_n), .in_valid(k_v_reg), .a(k_tadj_reg), .b(k_dy_reg),
        .tag({k_hit_reg, k_mdet_reg, k_p2y_reg}),
        .out_valid(nv[1]), .p(np[1]), .out_tag(nt[1]));
    sip_mul #(.WA(DB), .WB(D), .TW(T2)) u_mul_z (
        .clk(clk), .rst_n(rst_n), .in_valid(k_v_reg), .a(k_tadj_reg), .b(k_dz_reg),
        .tag({k_hit_reg, k_mdet_reg, k_p2z_reg}),
        .out_valid(nv[2]), .p(np[2]), .out_tag(nt[2]));

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        sip_div #(.DW(DB), .QW(D), .TW(T3)) u_div (
            .clk(clk), .rst_n(rst_n), .in_valid(nv[c]), .num(np[c]),
            .den(nt[c][DB+W-1:W]), .tag({nt[c][T2-1], nt[c][W-1:0]}),
            .out_valid(qv[c]), .q(qq[c]), .neg(qn[c]), .out_tag(qt[c]));
    end

    // p2 + signed quotient, zero on a miss
    always_comb
    begin
        logic signed [W+1:0] qs;
        logic signed [W+1:0] sum;
        logic [W-1:0]        co [3];
        for (int c = 0; c < 3; c++)
        begin
            qs    = qn[c] ? -$signed({1'b0, qq[c]}) : $signed({1'b0, qq[c]});
            sum   = $signed({qt[c][W-1], qt[c][W-1], qt[c][W-1:0]}) + qs;
            co[c] = qt[c][T3-1] ? sum[W-1:0] : '0;
        end
        out_next.hit     = qt[0][T3-1] & qt[1][T3-1] & qt[2][T3-1];
        out_next.cross_x = co[0];
        out_next.cross_y = co[1];
        out_next.cross_z = co[2];
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            c_v_reg  <= 1'b0;
            a_v_reg  <= 1'b0;
            k_v_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s0_v_reg <= start & ~busy;
            s1_v_reg <= s0_v_reg;
            c_v_reg  <= &pv;
            a_v_reg  <= c_v_reg;
            k_v_reg  <= a_v_reg;
            done_reg <= &qv;
        end
    end

    assign done   = done_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

FILE: rtl/sip_checker.sv
`default_nettype none

module sip_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input sip_pkg::sip_out_t result
);

    import sip_pkg::*;

    // pipeline never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");

    // a miss carries zero coordinates
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |->
        (result.cross_x == '0 && result.cross_y == '0 && result.cross_z == '0))
        else $error("miss with nonzero coordinates");

    // every result comes from an item taken a fixed number of edges before
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, SIP_LATENCY))
        else $error("result without matching item");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !done)
        else $error("result right after reset");

endmodule

bind segment_intersection_point sip_checker u_sip_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .result(result)
);

`default_nettype wire
